// ----- hdl/ulrat_pkg.sv -----
// ----------------------------------------------------------------------------
// ulrat_pkg
// Shared codes and types for the UART line receiver with AT prefix detect.
// ----------------------------------------------------------------------------
package ulrat_pkg;

	typedef enum logic [2:0] {
		MODE_BYTE    = 3'd0,
		MODE_OFF     = 3'd1,
		MODE_ARM_STR = 3'd2,
		MODE_ARM_AT  = 3'd3,
		MODE_ARM_RAW = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CAP_IDLE = 2'd0,
		CAP_LINE = 2'd1,
		CAP_RAW  = 2'd2
	} cap_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_FRAMING  = 2'd1,
		ERR_OVERRUN  = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef enum logic {
		CFG_TERMINATOR = 1'b0,
		CFG_ECHO       = 1'b1
	} cfg_reg_t;

	localparam logic [7:0] CHAR_A        = 8'h41;
	localparam logic [7:0] CHAR_T        = 8'h54;
	localparam logic [7:0] TERM_RESET    = 8'd13;

	// receiver control/status flags carried between the state and the step logic
	typedef struct packed {
		logic       receiver_on;
		logic [1:0] capture_state;
		logic [1:0] last_error;
		logic       prefix_done;
		logic       saw_letter_a;
	} ctl_t;

endpackage

// ----- hdl/ulrat_step.sv -----
// ----------------------------------------------------------------------------
// ulrat_step
// Next-state and result logic for one item of the line receiver.
// ----------------------------------------------------------------------------
module ulrat_step import ulrat_pkg::*; #(
	parameter int LINE_DEPTH = 32,
	parameter int CNT_W      = $clog2(LINE_DEPTH + 2)
) (
	input  logic [2:0]       mode,
	input  logic [7:0]       rx_byte,
	input  logic             framing_flag,
	input  logic             overrun_flag,
	input  logic             tx_free,
	input  logic [7:0]       term_char,
	input  logic             echo_en,
	input  ctl_t             cur_ctl,
	input  logic [CNT_W-1:0] cur_count,
	input  logic [CNT_W-1:0] cur_len,
	output ctl_t             nxt_ctl,
	output logic [CNT_W-1:0] nxt_count,
	output logic [CNT_W-1:0] nxt_len,
	output logic             store_valid,
	output logic [CNT_W-1:0] store_index,
	output logic [7:0]       store_byte,
	output logic             echo_valid
);

	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(LINE_DEPTH);

	logic full;

	assign full = (cur_count >= DEPTH);

	always_comb begin
		nxt_ctl     = cur_ctl;
		nxt_count   = cur_count;
		nxt_len     = cur_len;
		store_valid = 1'b0;
		store_index = '0;
		store_byte  = '0;
		echo_valid  = 1'b0;
		case (mode)
			MODE_BYTE: begin
				if (cur_ctl.receiver_on) begin
					// overrun wins over framing
					if (overrun_flag) begin
						nxt_ctl.last_error = ERR_OVERRUN;
					end else if (framing_flag) begin
						nxt_ctl.last_error = ERR_FRAMING;
					end
					echo_valid = echo_en & tx_free;
					case (cur_ctl.capture_state)
						CAP_RAW: begin
							if (full) begin
								nxt_ctl.last_error    = ERR_OVERFLOW;
								nxt_ctl.capture_state = CAP_IDLE;
							end else begin
								store_valid = 1'b1;
								store_index = cur_count;
								store_byte  = rx_byte;
								nxt_count   = cur_count + CNT_W'(1);
							end
						end
						CAP_LINE: begin
							if (cur_ctl.prefix_done) begin
								if (rx_byte == term_char) begin
									nxt_len               = cur_count + CNT_W'(1);
									nxt_ctl.capture_state = CAP_IDLE;
								end else if (full) begin
									nxt_ctl.last_error    = ERR_OVERFLOW;
									nxt_len               = DEPTH;
									nxt_ctl.capture_state = CAP_IDLE;
								end else begin
									store_valid = 1'b1;
									store_index = cur_count;
									store_byte  = rx_byte;
									nxt_count   = cur_count + CNT_W'(1);
								end
							end else begin
								// "AT" search
								if (rx_byte == CHAR_A) begin
									nxt_ctl.saw_letter_a = 1'b1;
								end else if (rx_byte == CHAR_T && cur_ctl.saw_letter_a) begin
									nxt_ctl.prefix_done = 1'b1;
								end else begin
									nxt_ctl.saw_letter_a = 1'b0;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			MODE_OFF: begin
				nxt_ctl.receiver_on = 1'b0;
			end
			MODE_ARM_STR, MODE_ARM_AT, MODE_ARM_RAW: begin
				nxt_count           = '0;
				nxt_len             = '0;
				nxt_ctl.last_error  = ERR_NONE;
				nxt_ctl.receiver_on = 1'b1;
				nxt_ctl.capture_state = (mode == MODE_ARM_RAW) ? CAP_RAW : CAP_LINE;
				nxt_ctl.prefix_done = (mode != MODE_ARM_AT);
				if (mode == MODE_ARM_AT) begin
					nxt_ctl.saw_letter_a = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/uart_line_receiver_at_detect_core.sv -----
// ----------------------------------------------------------------------------
// uart_line_receiver_at_detect_core
// UART receive line buffer control with optional AT prefix detection.
// ----------------------------------------------------------------------------
// Pipeline: an input transfer loads the input register; the item then moves
//   into the result register, whose outputs hold until they transfer out.
// Throughput: one item per cycle; the input register advances whenever the
//   result register is empty or being taken, so both sides stream.
// Reset: arst_n clears the receiver state, the pipeline valids, and loads
//   terminator 13 and echo off.
module uart_line_receiver_at_detect_core import ulrat_pkg::*; #(
	parameter int LINE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// item input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] mode,
	input  logic [7:0] rx_byte,
	input  logic       framing_flag,
	input  logic       overrun_flag,
	input  logic       tx_free,
	// configuration writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	// result output
	output logic       out_valid,
	input  logic       out_ready,
	output logic       store_valid,
	output logic [4:0] store_index,
	output logic [7:0] store_byte,
	output logic       echo_valid,
	output logic [5:0] byte_count,
	output logic [5:0] line_length,
	output logic [1:0] error_code,
	output logic [1:0] capture_mode,
	output logic       prefix_found
);

	// counts must reach LINE_DEPTH + 1 (line length includes the terminator)
	localparam int CNT_W = $clog2(LINE_DEPTH + 2);

	// input register stage
	logic       valid_s1;
	logic [2:0] mode_s1;
	logic [7:0] rx_byte_s1;
	logic       framing_s1;
	logic       overrun_s1;
	logic       tx_free_s1;

	// configuration
	logic [7:0] term_q;
	logic       echo_q;

	// receiver state
	ctl_t             ctl_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] len_q;

	// step results
	ctl_t             nxt_ctl;
	logic [CNT_W-1:0] nxt_count;
	logic [CNT_W-1:0] nxt_len;
	logic             st_valid;
	logic [CNT_W-1:0] st_index;
	logic [7:0]       st_byte;
	logic             ec_valid;

	// result register
	logic       out_valid_q;
	logic       store_valid_q;
	logic [4:0] store_index_q;
	logic [7:0] store_byte_q;
	logic       echo_valid_q;
	logic [5:0] byte_count_q;
	logic [5:0] line_length_q;
	logic [1:0] error_code_q;
	logic [1:0] capture_mode_q;
	logic       prefix_found_q;

	logic advance;

	// the held item is processed once the result slot frees up
	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1    <= mode;
			rx_byte_s1 <= rx_byte;
			framing_s1 <= framing_flag;
			overrun_s1 <= overrun_flag;
			tx_free_s1 <= tx_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_RESET;
			echo_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TERMINATOR: term_q <= cfg_data;
				CFG_ECHO:       echo_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ulrat_step #(
		.LINE_DEPTH (LINE_DEPTH),
		.CNT_W      (CNT_W)
	) u_step (
		.mode         (mode_s1),
		.rx_byte      (rx_byte_s1),
		.framing_flag (framing_s1),
		.overrun_flag (overrun_s1),
		.tx_free      (tx_free_s1),
		.term_char    (term_q),
		.echo_en      (echo_q),
		.cur_ctl      (ctl_q),
		.cur_count    (count_q),
		.cur_len      (len_q),
		.nxt_ctl      (nxt_ctl),
		.nxt_count    (nxt_count),
		.nxt_len      (nxt_len),
		.store_valid  (st_valid),
		.store_index  (st_index),
		.store_byte   (st_byte),
		.echo_valid   (ec_valid)
	);

	// state commits together with the result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '0;
			count_q <= '0;
			len_q   <= '0;
		end else if (advance) begin
			ctl_q   <= nxt_ctl;
			count_q <= nxt_count;
			len_q   <= nxt_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output fields are the low bits of the internal counts
	always_ff @(posedge clk) begin
		if (advance) begin
			store_valid_q  <= st_valid;
			store_index_q  <= 5'(st_index);
			store_byte_q   <= st_byte;
			echo_valid_q   <= ec_valid;
			byte_count_q   <= 6'(nxt_count);
			line_length_q  <= 6'(nxt_len);
			error_code_q   <= nxt_ctl.last_error;
			capture_mode_q <= nxt_ctl.capture_state;
			prefix_found_q <= nxt_ctl.prefix_done;
		end
	end

	assign out_valid    = out_valid_q;
	assign store_valid  = store_valid_q;
	assign store_index  = store_index_q;
	assign store_byte   = store_byte_q;
	assign echo_valid   = echo_valid_q;
	assign byte_count   = byte_count_q;
	assign line_length  = line_length_q;
	assign error_code   = error_code_q;
	assign capture_mode = capture_mode_q;
	assign prefix_found = prefix_found_q;

endmodule

// ----- hdl/ulrat_checker.sv -----
// ----------------------------------------------------------------------------
// ulrat_checker
// Port-level checks for the line receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ulrat_checker import ulrat_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       store_valid,
	input logic [4:0] store_index,
	input logic [7:0] store_byte,
	input logic [5:0] byte_count,
	input logic [5:0] line_length,
	input logic [1:0] error_code,
	input logic [1:0] capture_mode,
	input logic       prefix_found
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(store_index)
			&& $stable(store_byte) && $stable(byte_count))
		else $error("result changed while stalled");

	// a store leaves an active capture with the count one past the index
	a_store: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_valid |-> capture_mode != CAP_IDLE && prefix_found
			&& byte_count[4:0] == store_index + 5'd1)
		else $error("store inconsistent with capture status");

	// overflow always ends the capture
	a_overflow_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_OVERFLOW |-> capture_mode == CAP_IDLE)
		else $error("overflow with capture still active");

	// a completed line means the capture is over
	a_line_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_length != 6'd0 |-> capture_mode == CAP_IDLE)
		else $error("line length set during capture");

endmodule

bind uart_line_receiver_at_detect_core ulrat_checker u_ulrat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.store_valid  (store_valid),
	.store_index  (store_index),
	.store_byte   (store_byte),
	.byte_count   (byte_count),
	.line_length  (line_length),
	.error_code   (error_code),
	.capture_mode (capture_mode),
	.prefix_found (prefix_found)
);
